@@ hw/rtl/dtr_pkg.sv @@
`timescale 1ns / 1ps

package dtr_pkg;

  localparam int SUM_W = 11;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [3:0] OFF_DIV  = 4'd4;
  localparam logic [3:0] OFF_TIMA = 4'd5;
  localparam logic [3:0] OFF_TMA  = 4'd6;
  localparam logic [3:0] OFF_TAC  = 4'd7;
  localparam logic [3:0] OFF_IF   = 4'd15;

  localparam logic [7:0] TIMER_FLAG = 8'h04;
  localparam logic [7:0] UNMAPPED   = 8'hFF;
  localparam logic [7:0] TIMA_TOP   = 8'hFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] cycles;
    logic [3:0] reg_offset;
    logic [7:0] write_value;
  } req_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] interrupt_flags;
  } rsp_item_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic load;
  } dtr_cmd_t;

  typedef struct packed {
    logic req_tick;
    logic div_busy;
    logic tim_busy;
  } dtr_sts_t;

  function automatic logic [SUM_W-1:0] timer_period(input logic [1:0] sel);
    logic [SUM_W-1:0] p;
    case (sel)
      2'd0:    p = SUM_W'(1024);
      2'd1:    p = SUM_W'(16);
      2'd2:    p = SUM_W'(64);
      default: p = SUM_W'(256);
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/dtr_ctrl.sv @@
`timescale 1ns / 1ps

module dtr_ctrl
  import dtr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  input  dtr_sts_t sts,
  output dtr_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_STEP   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.req_tick ? ST_STEP : ST_FINISH;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (!sts.div_busy && !sts.tim_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign req_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/dtr_datapath.sv @@
`timescale 1ns / 1ps

module dtr_datapath
  import dtr_pkg::*;
#(
  parameter int DIV_PERIOD = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  req_item_t req,
  input  dtr_cmd_t  cmd,
  output dtr_sts_t  sts,
  output rsp_item_t rsp
);

  localparam int LW = (DIV_PERIOD > 1) ? $clog2(DIV_PERIOD) : 1;
  localparam logic [SUM_W-1:0] DIV_D = SUM_W'(DIV_PERIOD);
  localparam int SH = SUM_W + $clog2(DIV_PERIOD);
  localparam int MW = SUM_W + 2;
  localparam int PW = SH + SUM_W;
  localparam logic [MW-1:0] RECIP = MW'(((1 << SH) + DIV_PERIOD - 1) / DIV_PERIOD);

  logic [7:0]       div_cnt;
  logic [LW-1:0]    div_left;
  logic [7:0]       tim_cnt;
  logic [9:0]       tim_left;
  logic [7:0]       tma;
  logic [7:0]       tac;
  logic [7:0]       flags;
  logic [7:0]       rd;
  logic             div_busy;
  logic             tim_busy;
  logic             div_ph;
  logic [SUM_W-1:0] dsum;
  logic [SUM_W-1:0] dq;
  logic [SUM_W-1:0] tsum;

  logic [PW-1:0]    prod;
  logic [SUM_W-1:0] q_calc;
  logic [SUM_W-1:0] rem_calc;
  logic [SUM_W-1:0] period;
  logic [7:0]       rd_mux;

  // quotient by reciprocal multiply, remainder on the following step
  assign prod     = PW'(dsum) * PW'(RECIP);
  assign q_calc   = prod[PW-1:SH];
  assign rem_calc = dsum - dq * DIV_D;
  assign period   = timer_period(tac[1:0]);

  always_comb begin
    case (req.reg_offset)
      OFF_DIV:  rd_mux = div_cnt;
      OFF_TIMA: rd_mux = tim_cnt;
      OFF_TMA:  rd_mux = tma;
      OFF_TAC:  rd_mux = tac;
      OFF_IF:   rd_mux = flags;
      default:  rd_mux = UNMAPPED;
    endcase
  end

  assign sts.req_tick = (req.kind == KIND_TICK);
  assign sts.div_busy = div_busy;
  assign sts.tim_busy = tim_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt  <= '0;
      div_left <= '0;
      tim_cnt  <= '0;
      tim_left <= '0;
      tma      <= '0;
      tac      <= '0;
      flags    <= '0;
      div_busy <= 1'b0;
      tim_busy <= 1'b0;
      div_ph   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        rd <= (req.kind == KIND_READ) ? rd_mux : UNMAPPED;
        case (req.kind)
          KIND_TICK: begin
            dsum     <= SUM_W'(req.cycles) + SUM_W'(div_left);
            div_ph   <= 1'b0;
            tsum     <= SUM_W'(req.cycles) + SUM_W'(tim_left);
            div_busy <= 1'b1;
            tim_busy <= 1'b1;
          end
          KIND_WRITE: begin
            case (req.reg_offset)
              OFF_DIV:  div_cnt <= '0;
              OFF_TIMA: tim_cnt <= req.write_value;
              OFF_TMA:  tma     <= req.write_value;
              OFF_TAC:  tac     <= req.write_value;
              OFF_IF:   flags   <= req.write_value;
              default:  ;
            endcase
          end
          default: ;
        endcase
      end
      if (cmd.step && div_busy) begin
        if (!div_ph) begin
          dq     <= q_calc;
          div_ph <= 1'b1;
        end else begin
          div_busy <= 1'b0;
          div_cnt  <= div_cnt + dq[7:0];
          div_left <= rem_calc[LW-1:0];
        end
      end
      if (cmd.step && tim_busy) begin
        if (tsum >= period) begin
          tsum <= tsum - period;
          if (tim_cnt == TIMA_TOP) begin
            flags   <= flags | TIMER_FLAG;
            tim_cnt <= tma;
          end else begin
            tim_cnt <= tim_cnt + 8'd1;
          end
        end else begin
          tim_busy <= 1'b0;
          tim_left <= tsum[9:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp.read_data       <= rd;
      rsp.interrupt_flags <= flags;
    end
  end

endmodule

@@ hw/rtl/divider_timer_with_reload.sv @@
`timescale 1ns / 1ps

// Timer peripheral: free-running divider plus a reloading counter that sets
// bit 2 of the interrupt flags on overflow. One item in, one item out. A
// tick causes n counter steps (at most 79): the divider quotient comes
// from a reciprocal multiply and the remainder in the next cycle, while
// the counter advances one step per cycle alongside. One item is in work
// at a time; the result sits in an output register, so a waiting result
// holds off only the finish of the following item.
module divider_timer_with_reload
  import dtr_pkg::*;
#(
  parameter int DIV_PERIOD = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  dtr_cmd_t cmd;
  dtr_sts_t sts;

  dtr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtr_datapath #(
    .DIV_PERIOD (DIV_PERIOD)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("accepted item did not make the block busy");

  a_tick_starts_units: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.kind == KIND_TICK) |=> (sts.div_busy && sts.tim_busy))
    else $error("tick did not start divider and counter");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.step, cmd.load}))
    else $error("controller issued overlapping commands");

  a_load_when_idle_units: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!sts.div_busy && !sts.tim_busy))
    else $error("result loaded while a unit was still busy");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import dtr_pkg::*;

  localparam int DIV_PERIOD = 256;
  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT = 600000;
  localparam int IDLE_PCT = 24;
  localparam logic [1:0] KIND_NONE = 2'd3;

  class timer_shadow;
    logic [7:0] div_count;
    int         div_left;
    logic [7:0] tima;
    int         tim_left;
    logic [7:0] tma;
    logic [7:0] tac;
    logic [7:0] flags;
    rsp_item_t  due_rsp[$];
    int         errors;

    function new();
      div_count = '0;
      div_left  = 0;
      tima      = '0;
      tim_left  = 0;
      tma       = '0;
      tac       = '0;
      flags     = '0;
      errors    = 0;
    endfunction

    function int step_period(logic [1:0] sel);
      case (sel)
        2'd0:    return 1024;
        2'd1:    return 16;
        2'd2:    return 64;
        default: return 256;
      endcase
    endfunction

    function void run_ticks(logic [7:0] n);
      int dsum;
      int tsum;
      int period;
      dsum = int'(n) + div_left;
      tsum = int'(n) + tim_left;
      period = step_period(tac[1:0]);
      div_count = 8'(int'(div_count) + dsum / DIV_PERIOD);
      div_left = dsum % DIV_PERIOD;
      while (tsum >= period) begin
        if (tima == TIMA_TOP) begin
          flags = flags | TIMER_FLAG;
          tima = tma;
        end else begin
          tima = tima + 8'd1;
        end
        tsum -= period;
      end
      tim_left = tsum;
    endfunction

    function void note_request(req_item_t it);
      rsp_item_t r;
      r.read_data = UNMAPPED;
      case (it.kind)
        KIND_TICK: run_ticks(it.cycles);
        KIND_WRITE: begin
          case (it.reg_offset)
            OFF_DIV:  div_count = '0;
            OFF_TIMA: tima = it.write_value;
            OFF_TMA:  tma = it.write_value;
            OFF_TAC:  tac = it.write_value;
            OFF_IF:   flags = it.write_value;
            default: ;
          endcase
        end
        KIND_READ: begin
          case (it.reg_offset)
            OFF_DIV:  r.read_data = div_count;
            OFF_TIMA: r.read_data = tima;
            OFF_TMA:  r.read_data = tma;
            OFF_TAC:  r.read_data = tac;
            OFF_IF:   r.read_data = flags;
            default:  r.read_data = UNMAPPED;
          endcase
        end
        default: ;
      endcase
      r.interrupt_flags = flags;
      due_rsp.push_back(r);
    endfunction

    function void check_response(rsp_item_t got);
      rsp_item_t want;
      if (due_rsp.size() == 0) begin
        $error("unexpected item: read_data %0h interrupt_flags %0h",
               got.read_data, got.interrupt_flags);
        errors++;
        return;
      end
      want = due_rsp.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
        errors++;
      end
      if (got.interrupt_flags !== want.interrupt_flags) begin
        $error("interrupt_flags: expected %0h, got %0h",
               want.interrupt_flags, got.interrupt_flags);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  req_item_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  rsp_item_t rsp;

  logic        calm;
  int          cycle_count;
  timer_shadow shadow;

  divider_timer_with_reload #(
    .DIV_PERIOD(DIV_PERIOD)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    shadow = new();
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[divider_timer_with_reload] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) shadow.note_request(req);
      if (rsp_valid && !rsp_stall) shadow.check_response(rsp);
    end
  end

  always @(posedge clk) begin
    rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic issue(input logic [1:0] k, input logic [7:0] c,
                       input logic [3:0] o, input logic [7:0] v);
    req_item_t it;
    it.kind = k;
    it.cycles = c;
    it.reg_offset = o;
    it.write_value = v;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic drain;
    req_valid <= 1'b0;
    @(posedge clk);
    while (shadow.due_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic [3:0] pick_offset(input int mapped_pct);
    if ($urandom_range(99) >= mapped_pct) return 4'($urandom_range(15));
    case ($urandom_range(4))
      0:       return OFF_DIV;
      1:       return OFF_TIMA;
      2:       return OFF_TMA;
      3:       return OFF_TAC;
      default: return OFF_IF;
    endcase
  endfunction

  task automatic random_item;
    logic [1:0] k;
    logic [7:0] c;
    logic [3:0] o;
    logic [7:0] v;
    int         r;
    r = $urandom_range(99);
    c = 8'($urandom_range(255));
    o = 4'($urandom_range(15));
    v = 8'($urandom_range(255));
    if (r < 45) begin
      k = KIND_TICK;
      if ($urandom_range(9) == 0) c = $urandom_range(1) ? 8'hFF : 8'h00;
    end else if (r < 70) begin
      k = KIND_WRITE;
      o = pick_offset(90);
      if (o == OFF_TIMA && $urandom_range(2) == 0) v = 8'($urandom_range(255, 240));
    end else if (r < 95) begin
      k = KIND_READ;
      o = pick_offset(85);
    end else begin
      k = KIND_NONE;
    end
    issue(k, c, o, v);
  endtask

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    calm <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset values, unmapped read, unused kind
    issue(KIND_READ, 8'h00, OFF_DIV, 8'h00);
    issue(KIND_READ, 8'hFF, OFF_TIMA, 8'hFF);
    issue(KIND_READ, 8'h00, 4'd0, 8'h00);
    issue(KIND_NONE, 8'hFF, 4'hF, 8'hFF);
    // divider carry across ticks
    issue(KIND_TICK, 8'h00, 4'd0, 8'h00);
    issue(KIND_TICK, 8'hFF, 4'd0, 8'h00);
    issue(KIND_TICK, 8'h01, 4'd0, 8'h00);
    // overflow with reload
    issue(KIND_WRITE, 8'h00, OFF_TMA, 8'hAB);
    issue(KIND_WRITE, 8'h00, OFF_TAC, 8'h01);
    issue(KIND_WRITE, 8'h00, OFF_TIMA, 8'hFF);
    issue(KIND_TICK, 8'd16, 4'd0, 8'h00);
    issue(KIND_READ, 8'h00, OFF_TIMA, 8'h00);
    issue(KIND_READ, 8'h00, OFF_IF, 8'h00);
    issue(KIND_WRITE, 8'h00, OFF_IF, 8'h00);
    // divider clear, unmapped write
    issue(KIND_WRITE, 8'h00, OFF_DIV, 8'h5A);
    issue(KIND_READ, 8'h00, OFF_DIV, 8'h00);
    issue(KIND_WRITE, 8'h00, 4'd3, 8'h77);
    // long-period leftover then consumed at the short period
    issue(KIND_WRITE, 8'h00, OFF_TAC, 8'hFC);
    repeat (4) issue(KIND_TICK, 8'hFF, 4'd0, 8'h00);
    issue(KIND_WRITE, 8'h00, OFF_TAC, 8'h01);
    issue(KIND_TICK, 8'hFF, 4'd0, 8'h00);
    issue(KIND_WRITE, 8'h00, OFF_TAC, 8'hFF);
    issue(KIND_READ, 8'h00, OFF_TAC, 8'h00);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) calm <= 1'b1;
      if (i == 500) calm <= 1'b0;
      if (i == 700) drain();
      random_item();
    end
    req_valid <= 1'b0;

    while (shadow.due_rsp.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("[divider_timer_with_reload] OK");
    end else begin
      $display("[divider_timer_with_reload] ERROR");
    end
    $finish;
  end

endmodule

@@ divider_timer_with_reload.f @@
hw/rtl/dtr_pkg.sv
hw/rtl/dtr_ctrl.sv
hw/rtl/dtr_datapath.sv
hw/rtl/divider_timer_with_reload.sv
tb/tb.sv
